>>> design/wsfc_pkg.sv
// shared types, sizes and the bit-weight function for the weighted-sum frame checker
// no dependencies; every other design file refers to this package by scoped names

package wsfc_pkg;

	localparam int FRAME_BYTES = 16;
	localparam int CHECK_BYTES = 4;
	localparam int DATA_BYTES = FRAME_BYTES - CHECK_BYTES;
	localparam int PAYLOAD_BYTES = 12;
	localparam int DATA_STORE = (DATA_BYTES < PAYLOAD_BYTES) ? DATA_BYTES : PAYLOAD_BYTES;
	localparam int LOW_CHECK_BYTES = CHECK_BYTES - 1;
	localparam int CHECK_W = 8 * CHECK_BYTES;
	localparam int WORD_W = 32;

	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam int WEIGHT_MAX = 36;
	localparam int WEIGHT_W = $clog2(WEIGHT_MAX + 1);
	localparam int SUM_MAX = WEIGHT_MAX * DATA_BYTES * (DATA_BYTES + 1) / 2;
	localparam int SUM_W = $clog2(SUM_MAX + 1);
	localparam int PROD_W = POS_W + WEIGHT_W;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [WEIGHT_W-1:0] weight_t;

	// one byte beat as held in the input register
	typedef struct packed {
		logic [7:0] rx_byte;
		weight_t    weight;
	} step_t;

	typedef struct packed {
		logic              frame_ok;
		logic [WORD_W-1:0] payload_word0;
		logic [WORD_W-1:0] payload_word1;
		logic [WORD_W-1:0] payload_word2;
	} result_t;

	// sum of (b+1) over the set bits b of a byte
	function automatic weight_t bit_weight(input logic [7:0] v);
		weight_t w;
		w = '0;
		for (int b = 0; b < 8; b++) begin
			if (v[b]) begin
				w = w + weight_t'(b + 1);
			end
		end
		return w;
	endfunction

endpackage

>>> design/weighted_sum_frame_checker_unit.sv
// top level of the weighted-sum frame checker: input stage, frame core, result register
// depends on wsfc_pkg, wsfc_in_stage and wsfc_core
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  in       | in_valid / in_ready  | rx_byte (8)
//  out      | out_valid / out_ready| frame_ok (1), payload_word0..2 (32 each)
//
// one byte beat per cycle sustained unless a pending result stalls the input; a byte is
// registered, then framed and summed in the core as it leaves the input register, and a
// frame result is loaded into the result register as the last check byte leaves it
// the running sum is 12 bits wide, one add of a registered weight scaled by its position per data beat
// reset clears framing position, sum, drop flag and both valid bits; stores are not cleared
// a pending result only stalls the input when the next byte would itself end a frame

module weighted_sum_frame_checker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_ok,
	output logic [31:0] payload_word0,
	output logic [31:0] payload_word1,
	output logic [31:0] payload_word2
);

	logic              s1_valid;
	wsfc_pkg::step_t   step_s1;
	logic              emit;
	wsfc_pkg::result_t result;
	wsfc_pkg::result_t result_q;
	logic              out_valid_q;
	logic              advance;

	// registered byte beat plus its bit weight
	wsfc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.s1_valid (s1_valid),
		.step_s1  (step_s1)
	);

	// the held byte moves on unless it ends a frame and the result slot is still full
	assign advance = s1_valid && (!emit || !out_valid_q || out_ready);

	wsfc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.step   (step_s1),
		.emit   (emit),
		.result (result)
	);

	// result register, refilled in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_ok = result_q.frame_ok;
	assign payload_word0 = result_q.payload_word0;
	assign payload_word1 = result_q.payload_word1;
	assign payload_word2 = result_q.payload_word2;

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> out_valid_q)
		else $error("frame result not loaded into the result register");

	a_stall_keeps_byte: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !advance |=> s1_valid)
		else $error("stalled byte lost from the input register");

	a_stall_only_on_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !advance |-> emit && out_valid_q && !out_ready)
		else $error("input stage stalled without a blocked frame result");

endmodule

>>> design/wsfc_in_stage.sv
// input register of the frame checker: holds one byte beat and its bit weight
// depends on wsfc_pkg

module wsfc_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	input  logic               advance,
	output logic               s1_valid,
	output wsfc_pkg::step_t    step_s1
);

	logic valid_s1;

	assign in_ready = !valid_s1 || advance;
	assign s1_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			step_s1.rx_byte <= rx_byte;
			step_s1.weight <= wsfc_pkg::bit_weight(rx_byte);
		end
	end

endmodule

>>> design/wsfc_core.sv
// framing state, weighted sum, payload and check-byte stores of the frame checker
// depends on wsfc_pkg

module wsfc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  wsfc_pkg::step_t     step,
	output logic                emit,
	output wsfc_pkg::result_t   result
);

	wsfc_pkg::pos_t pos_q;
	logic           drop_q;
	wsfc_pkg::sum_t sum_q;
	logic [7:0]     store_q [wsfc_pkg::DATA_STORE];
	logic [7:0]     check_low_q [wsfc_pkg::LOW_CHECK_BYTES];

	logic                               is_last;
	logic                               is_data;
	logic                               ok;
	logic [wsfc_pkg::PROD_W-1:0]        prod;
	wsfc_pkg::sum_t                     sum_next;
	logic [8*wsfc_pkg::PAYLOAD_BYTES-1:0] payload_flat;
	logic [wsfc_pkg::CHECK_W-1:0]       check_word;

	assign is_last = pos_q >= wsfc_pkg::pos_t'(wsfc_pkg::FRAME_BYTES - 1);
	assign is_data = pos_q < wsfc_pkg::pos_t'(wsfc_pkg::DATA_BYTES);
	assign emit = !drop_q && is_last;

	// weight of this byte scaled by its 1-based position
	assign prod = wsfc_pkg::PROD_W'(pos_q + wsfc_pkg::pos_t'(1)) * wsfc_pkg::PROD_W'(step.weight);
	assign sum_next = sum_q + wsfc_pkg::sum_t'(prod);

	assign check_word = {step.rx_byte, check_low_q[2], check_low_q[1], check_low_q[0]};
	assign ok = check_word == wsfc_pkg::CHECK_W'(sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			drop_q <= 1'b0;
			sum_q <= '0;
		end else if (fire) begin
			if (drop_q) begin
				drop_q <= 1'b0;
			end else if (is_last) begin
				pos_q <= '0;
				sum_q <= '0;
				drop_q <= !ok;
			end else begin
				pos_q <= pos_q + wsfc_pkg::pos_t'(1);
				if (is_data) begin
					sum_q <= sum_next;
				end
			end
		end
	end

	// data bytes land at the store entry of their frame position, the first three check bytes past the data region
	for (genvar e = 0; e < wsfc_pkg::DATA_STORE; e++) begin : g_store
		always_ff @(posedge clk) begin
			if (fire && !drop_q && pos_q == wsfc_pkg::pos_t'(e)) begin
				store_q[e] <= step.rx_byte;
			end
		end
	end

	for (genvar k = 0; k < wsfc_pkg::LOW_CHECK_BYTES; k++) begin : g_check
		always_ff @(posedge clk) begin
			if (fire && !drop_q && pos_q == wsfc_pkg::pos_t'(wsfc_pkg::DATA_BYTES + k)) begin
				check_low_q[k] <= step.rx_byte;
			end
		end
	end

	// payload bytes past the data region read zero
	for (genvar i = 0; i < wsfc_pkg::PAYLOAD_BYTES; i++) begin : g_pack
		if (i < wsfc_pkg::DATA_STORE) begin : g_live
			assign payload_flat[8*i +: 8] = store_q[i];
		end else begin : g_zero
			assign payload_flat[8*i +: 8] = 8'h00;
		end
	end

	assign result.frame_ok = ok;
	assign result.payload_word0 = payload_flat[31:0];
	assign result.payload_word1 = payload_flat[63:32];
	assign result.payload_word2 = payload_flat[95:64];

	a_fail_sets_drop: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit && !ok |=> drop_q)
		else $error("failed frame did not arm the byte drop");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |=> pos_q == '0 && sum_q == '0)
		else $error("framing state not cleared after a frame");

	a_drop_holds_frame: assert property (@(posedge clk) disable iff (!arst_n)
		fire && drop_q |=> !drop_q && $stable(pos_q) && $stable(sum_q))
		else $error("dropped byte disturbed the framing state");

endmodule
